>>> rtl/vmd_pkg.sv
`default_nettype none

package vmd_pkg;

  // Volume limits and derived sizes.
  localparam int MAX_X = 256;
  localparam int MAX_Y = 256;
  localparam int MAX_Z = 256;
  localparam int HALF_X = MAX_X / 2;
  localparam int HALF_Y = MAX_Y / 2;

  localparam int SAMPLE_W = 16;
  localparam int PAIR_W = SAMPLE_W + 1;
  localparam int QUAD_W = SAMPLE_W + 2;
  localparam int SUM_W = SAMPLE_W + 3;

  localparam int CFG_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam int POS_X_W = $clog2(MAX_X);
  localparam int POS_Y_W = $clog2(MAX_Y);
  localparam int POS_Z_W = $clog2(MAX_Z);
  localparam int OX_W = $clog2(HALF_X);
  localparam int OY_W = $clog2(HALF_Y);
  localparam int PLANE_AW = OX_W + OY_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  typedef enum logic [1:0] {
    OP_ROW_WR   = 2'd0,
    OP_PLANE_WR = 2'd1,
    OP_MEAN     = 2'd2
  } op_e;

  // One queued work item from the front to the back.
  typedef struct packed {
    op_e                      op;
    logic [OX_W-1:0]          ox;
    logic [OY_W-1:0]          oy;
    logic signed [PAIR_W-1:0] pair;
    logic                     last;
  } q_entry_t;

endpackage

`default_nettype wire

>>> rtl/vmd_if.sv
`default_nettype none

interface vmd_sample_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface vmd_result_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   mean_value;
  logic                 last_of_volume;

  modport source (output valid, output mean_value, output last_of_volume, input ready);
  modport sink (input valid, input mean_value, input last_of_volume, output ready);
endinterface

`default_nettype wire

>>> rtl/vmd_front.sv
`default_nettype none

module vmd_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  vmd_sample_if.sink                         smp_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [vmd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [vmd_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output vmd_pkg::q_entry_t                  push_entry_o
);
  import vmd_pkg::*;

  logic [CFG_W-1:0] size_x_q, size_x_d;
  logic [CFG_W-1:0] size_y_q, size_y_d;
  logic [CFG_W-1:0] size_z_q, size_z_d;
  logic [POS_X_W-1:0] pos_x_q, pos_x_d;
  logic [POS_Y_W-1:0] pos_y_q, pos_y_d;
  logic [POS_Z_W-1:0] pos_z_q, pos_z_d;
  logic signed [SAMPLE_W-1:0] held_q;

  logic [CFG_W-1:0] sx, sy, sz;
  logic [CFG_W-2:0] nx, ny, nz;
  logic             accept, in_region, cfg_hit;
  logic             end_x, end_y, end_z;

  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                input logic [CFG_W-1:0] max);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > max) r = max;
    return r;
  endfunction

  assign sx = eff_size(size_x_q, CFG_W'(MAX_X));
  assign sy = eff_size(size_y_q, CFG_W'(MAX_Y));
  assign sz = eff_size(size_z_q, CFG_W'(MAX_Z));
  assign nx = sx[CFG_W-1:1];
  assign ny = sy[CFG_W-1:1];
  assign nz = sz[CFG_W-1:1];

  assign smp_i.ready = !q_full_i;
  assign accept = smp_i.valid && !q_full_i;

  // A sample counts only inside the even-sized part of the volume.
  assign in_region = (CFG_W'(pos_x_q) < {nx, 1'b0}) &&
                     (CFG_W'(pos_y_q) < {ny, 1'b0}) &&
                     (CFG_W'(pos_z_q) < {nz, 1'b0});

  assign end_x = CFG_W'(pos_x_q) == sx - CFG_W'(1);
  assign end_y = CFG_W'(pos_y_q) == sy - CFG_W'(1);
  assign end_z = CFG_W'(pos_z_q) == sz - CFG_W'(1);

  assign cfg_hit = cfg_we_i && (cfg_index_i == REG_SIZE_X || cfg_index_i == REG_SIZE_Y ||
                                cfg_index_i == REG_SIZE_Z);

  always_comb begin
    push_entry_o.ox = pos_x_q[POS_X_W-1:1];
    push_entry_o.oy = pos_y_q[POS_Y_W-1:1];
    push_entry_o.pair = PAIR_W'(held_q) + PAIR_W'(smp_i.sample);
    push_entry_o.last = ((CFG_W-1)'(pos_x_q[POS_X_W-1:1]) == nx - (CFG_W-1)'(1)) &&
                        ((CFG_W-1)'(pos_y_q[POS_Y_W-1:1]) == ny - (CFG_W-1)'(1)) &&
                        ((CFG_W-1)'(pos_z_q[POS_Z_W-1:1]) == nz - (CFG_W-1)'(1));
    if (!pos_y_q[0]) begin
      push_entry_o.op = OP_ROW_WR;
    end else if (!pos_z_q[0]) begin
      push_entry_o.op = OP_PLANE_WR;
    end else begin
      push_entry_o.op = OP_MEAN;
    end
  end

  assign push_o = accept && in_region && pos_x_q[0];

  always_comb begin
    size_x_d = size_x_q;
    size_y_d = size_y_q;
    size_z_d = size_z_q;
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    if (cfg_hit) begin
      case (cfg_index_i)
        REG_SIZE_X: size_x_d = cfg_data_i;
        REG_SIZE_Y: size_y_d = cfg_data_i;
        REG_SIZE_Z: size_z_d = cfg_data_i;
        default: ;
      endcase
      pos_x_d = '0;
      pos_y_d = '0;
      pos_z_d = '0;
    end else if (accept) begin
      if (end_x) begin
        pos_x_d = '0;
        if (end_y) begin
          pos_y_d = '0;
          pos_z_d = end_z ? '0 : pos_z_q + POS_Z_W'(1);
        end else begin
          pos_y_d = pos_y_q + POS_Y_W'(1);
        end
      end else begin
        pos_x_d = pos_x_q + POS_X_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= CFG_W'(MAX_X);
      size_y_q <= CFG_W'(MAX_Y);
      size_z_q <= CFG_W'(MAX_Z);
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else begin
      size_x_q <= size_x_d;
      size_y_q <= size_y_d;
      size_z_q <= size_z_d;
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !pos_x_q[0]) begin
      held_q <= smp_i.sample;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vmd_queue.sv
`default_nettype none

module vmd_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire vmd_pkg::q_entry_t  push_entry_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output vmd_pkg::q_entry_t       head_o,
  output logic                    avail_o
);
  import vmd_pkg::*;

  q_entry_t mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o = cnt_q == QCNT_W'(QDEPTH);
  assign avail_o = cnt_q != '0;
  assign head_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vmd_back.sv
`default_nettype none

module vmd_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire vmd_pkg::q_entry_t  head_i,
  input  wire logic               avail_i,
  output logic                    pop_o,
  vmd_result_if.source            res_o
);
  import vmd_pkg::*;

  logic signed [PAIR_W-1:0] row_mem [HALF_X];
  logic signed [QUAD_W-1:0] plane_mem [HALF_X * HALF_Y];

  logic                     b_valid_q, b_valid_d;
  q_entry_t                 b_q;
  logic signed [PAIR_W-1:0] row_rd_q;
  logic signed [QUAD_W-1:0] plane_rd_q;
  logic                     out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_mean_q;
  logic                     out_last_q;

  logic                     b_go;
  logic signed [QUAD_W-1:0] quad;
  logic signed [SUM_W-1:0]  sum;
  logic [PLANE_AW-1:0]      head_addr, b_addr;

  assign head_addr = {head_i.oy, head_i.ox};
  assign b_addr = {b_q.oy, b_q.ox};

  // A mean item leaves the stage only when the output register is free.
  assign b_go = b_valid_q && (b_q.op != OP_MEAN || !out_valid_q || res_o.ready);
  assign pop_o = avail_i && (!b_valid_q || b_go);

  assign quad = QUAD_W'(row_rd_q) + QUAD_W'(b_q.pair);
  assign sum = SUM_W'(plane_rd_q) + SUM_W'(quad);

  always_comb begin
    b_valid_d = b_valid_q;
    if (pop_o) begin
      b_valid_d = 1'b1;
    end else if (b_go) begin
      b_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (b_go && b_q.op == OP_MEAN) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The row store is written as the item leaves the queue, so an item right
  // behind it on the same column already sees the new pair.
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.op == OP_ROW_WR) begin
      row_mem[head_i.ox] <= head_i.pair;
    end
    if (pop_o) begin
      row_rd_q <= row_mem[head_i.ox];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go && b_q.op == OP_PLANE_WR) begin
      plane_mem[b_addr] <= quad;
    end
    if (pop_o) begin
      plane_rd_q <= plane_mem[head_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_q <= head_i;
    end
    if (b_go && b_q.op == OP_MEAN) begin
      out_mean_q <= sum[SUM_W-1:3];
      out_last_q <= b_q.last;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.mean_value = out_mean_q;
  assign res_o.last_of_volume = out_last_q;

endmodule

`default_nettype wire

>>> rtl/volume_mean_downsample_2x.sv
// 2x2x2 mean reduction of a streamed volume.
// Samples enter on smp_i in raster order, x fastest, then y, then z; results
// leave on res_o in raster order of the reduced volume, with last_of_volume
// set on the final one. Both channels use valid/ready; an item moves at a
// clock edge where both are high. Volume sizes are written through the
// cfg_we_i/cfg_index_i/cfg_data_i port, by the user only while the block is
// idle; the block does not enforce this. Any write to a size register
// restarts the position at the volume origin. One sample is taken every
// cycle while the queue is not full. The item that completes a block passes
// through the queue and then the back stage, whose column and plane store
// reads are registered alongside it, to the output register. The stores are
// single-port-write memories with registered reads and need no clearing:
// each entry is written earlier in the same volume than it is read. After
// reset the sizes are 256 on every axis and the position is at the origin.
// When the receiver stalls, the output register holds its item, the back
// stage and the four-entry queue fill, and only then does smp_i.ready drop.
`default_nettype none

module volume_mean_downsample_2x (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  vmd_sample_if.sink                         smp_i,
  vmd_result_if.source                       res_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [vmd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [vmd_pkg::CFG_W-1:0]     cfg_data_i
);
  import vmd_pkg::*;

  logic     push, q_full, pop, q_avail;
  q_entry_t push_entry, head;

  vmd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .smp_i        (smp_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  vmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_o       (head),
    .avail_o      (q_avail)
  );

  vmd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .avail_i (q_avail),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire
